/* rtl/core/lgs_pkg.sv */
`default_nettype none

package lgs_pkg;

  localparam int unsigned ROW_W        = 64;
  localparam int unsigned ROW_IDX_W    = 6;
  localparam int unsigned CFG_W        = 7;
  localparam int unsigned CFG_IDX_W    = 1;
  localparam int unsigned DEF_MAX_ROWS = 64;
  localparam int unsigned DEF_MAX_COLS = 64;
  localparam int unsigned CFG_RESET    = 64;

  // B3/S23 neighbor counts
  localparam logic [3:0] BIRTH_CNT   = 4'd3;
  localparam logic [3:0] SURVIVE_CNT = 4'd2;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_READ  = 2'd1,
    OP_STEP  = 2'd2
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROWS = 1'b0,
    CFG_COLS = 1'b1
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_STEP,
    ST_FIN
  } state_e;

  typedef struct packed {
    logic [1:0]           op;
    logic [ROW_IDX_W-1:0] row_index;
    logic [ROW_W-1:0]     row_cells;
  } in_t;

  typedef struct packed {
    logic [ROW_IDX_W-1:0] row_index_out;
    logic [ROW_W-1:0]     row_cells_out;
    logic                 step_done;
  } out_t;

endpackage

`default_nettype wire

/* rtl/core/lgs_lane.sv */
`default_nettype none

module lgs_lane (
  input  wire logic [8:0] win_i,   // 3x3 window, bit 4 is the cell itself
  input  wire logic       en_i,
  output logic            alive_o
);

  logic [3:0] cnt;

  always_comb begin
    cnt = 4'd0;
    for (int k = 0; k < 9; k++) begin
      if (k != 4) begin
        cnt = cnt + 4'(win_i[k]);
      end
    end
  end

  assign alive_o = en_i && ((cnt == lgs_pkg::BIRTH_CNT) ||
                            (win_i[4] && (cnt == lgs_pkg::SURVIVE_CNT)));

endmodule

`default_nettype wire

/* rtl/core/lgs_row_eval.sv */
`default_nettype none

module lgs_row_eval #(
  parameter int unsigned NumLanes = lgs_pkg::DEF_MAX_COLS
) (
  input  wire logic [lgs_pkg::ROW_W-1:0] up_i,
  input  wire logic [lgs_pkg::ROW_W-1:0] mid_i,
  input  wire logic [lgs_pkg::ROW_W-1:0] dn_i,
  input  wire logic [lgs_pkg::ROW_W-1:0] en_i,
  output logic      [lgs_pkg::ROW_W-1:0] row_o
);

  // pad one dead column on each side
  logic [lgs_pkg::ROW_W+1:0] up_pad;
  logic [lgs_pkg::ROW_W+1:0] mid_pad;
  logic [lgs_pkg::ROW_W+1:0] dn_pad;
  logic [NumLanes-1:0]       lane_alive;

  assign up_pad  = {1'b0, up_i, 1'b0};
  assign mid_pad = {1'b0, mid_i, 1'b0};
  assign dn_pad  = {1'b0, dn_i, 1'b0};

  for (genvar j = 0; j < NumLanes; j++) begin : g_lane
    lgs_lane u_lane (
      .win_i   ({dn_pad[j+2:j], mid_pad[j+2:j], up_pad[j+2:j]}),
      .en_i    (en_i[j]),
      .alive_o (lane_alive[j])
    );
  end

  // merge lanes into one row word, columns above the lanes stay dead
  assign row_o = lgs_pkg::ROW_W'(lane_alive);

endmodule

`default_nettype wire

/* rtl/core/lgs_grid_mem.sv */
`default_nettype none

module lgs_grid_mem #(
  parameter int unsigned Depth = lgs_pkg::DEF_MAX_ROWS,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  wire logic                        clk_i,
  input  wire logic                        wr_en_i,
  input  wire logic [AddrW-1:0]            wr_addr_i,
  input  wire logic [lgs_pkg::ROW_W-1:0]   wr_data_i,
  input  wire logic                        rd_en_i,
  input  wire logic [AddrW-1:0]            rd_addr_i,
  output logic      [lgs_pkg::ROW_W-1:0]   rd_data_o
);

  logic [lgs_pkg::ROW_W-1:0] mem_q [Depth];
  logic [lgs_pkg::ROW_W-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // read data holds until the next read
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

/* rtl/core/life_generation_step.sv */
// Channel  | Direction | Signals                            | Handshake
// ---------+-----------+------------------------------------+--------------------
// in       | input     | in_data_i (op, row_index, cells)   | in_valid_i/in_ready_o
// out      | output    | out_data_o (row, cells, step_done) | out_valid_o/out_ready_i
// cfg      | input     | cfg_idx_i, cfg_wdata_i             | cfg_we_i, no wait
//
// Write, read and unused-op items pass from the accept cycle through ST_FIN. A step streams
// min(rows_in_use, MAX_ROWS) grid rows, one per cycle, through a three-row window while the
// lanes write back the row above; with no rows in use it goes straight to ST_FIN.
// After reset a clearing pass writes MAX_ROWS rows, one per cycle, before in_ready_o rises.
// The result register holds one finished transaction, so the next item is taken
// while it waits; a stalled output holds the block in its final cycle.
`default_nettype none

module life_generation_step #(
  parameter int unsigned MAX_ROWS = lgs_pkg::DEF_MAX_ROWS,
  parameter int unsigned MAX_COLS = lgs_pkg::DEF_MAX_COLS
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           in_valid_i,
  output logic                                in_ready_o,
  input  wire lgs_pkg::in_t                   in_data_i,
  output logic                                out_valid_o,
  input  wire logic                           out_ready_i,
  output lgs_pkg::out_t                       out_data_o,
  input  wire logic                           cfg_we_i,
  input  wire logic [lgs_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [lgs_pkg::CFG_W-1:0]      cfg_wdata_i
);

  localparam int unsigned AW = $clog2(MAX_ROWS);
  localparam int unsigned RW = $clog2(MAX_ROWS + 1);

  lgs_pkg::state_e state_q, state_d;

  logic [lgs_pkg::CFG_W-1:0] rows_q, cols_q;
  logic [RW-1:0]             s_q, s_d;
  logic [AW-1:0]             clr_q, clr_d;
  logic [lgs_pkg::ROW_W-1:0] up_q, up_d, mid_q, mid_d;

  logic [1:0]                     pend_op_q, pend_op_d;
  logic [lgs_pkg::ROW_IDX_W-1:0]  pend_row_q, pend_row_d;
  logic                           pend_ok_q, pend_ok_d;
  logic [lgs_pkg::ROW_W-1:0]      pend_cells_q, pend_cells_d;

  logic           out_valid_q, out_valid_d;
  lgs_pkg::out_t  out_q, out_d;

  logic                      wr_en, rd_en;
  logic [AW-1:0]             wr_addr, rd_addr;
  logic [lgs_pkg::ROW_W-1:0] wr_data, rd_data;

  logic [lgs_pkg::CFG_W-1:0] c_eff;
  logic [RW-1:0]             r_eff;
  logic [lgs_pkg::ROW_W-1:0] col_mask;
  logic [lgs_pkg::ROW_W-1:0] incoming;
  logic [lgs_pkg::ROW_W-1:0] next_row;
  logic [RW:0]               s_nxt;
  logic                      in_row_ok;

  assign c_eff = (cols_q > lgs_pkg::CFG_W'(MAX_COLS)) ? lgs_pkg::CFG_W'(MAX_COLS) : cols_q;
  assign r_eff = (32'(rows_q) > 32'(MAX_ROWS)) ? RW'(MAX_ROWS) : RW'(rows_q);

  always_comb begin
    for (int j = 0; j < int'(lgs_pkg::ROW_W); j++) begin
      col_mask[j] = (lgs_pkg::CFG_W'(j) < c_eff);
    end
  end

  assign in_row_ok = (32'(in_data_i.row_index) < 32'(MAX_ROWS));
  assign s_nxt     = {1'b0, s_q} + (RW + 1)'(1);
  // rows past the rows in use count as dead
  assign incoming  = (s_q < r_eff) ? (rd_data & col_mask) : '0;

  lgs_grid_mem #(
    .Depth (MAX_ROWS)
  ) u_mem (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  lgs_row_eval #(
    .NumLanes (MAX_COLS)
  ) u_eval (
    .up_i  (up_q),
    .mid_i (mid_q),
    .dn_i  (incoming),
    .en_i  (col_mask),
    .row_o (next_row)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= lgs_pkg::ST_CLEAR;
      clr_q       <= '0;
      s_q         <= '0;
      out_valid_q <= 1'b0;
      pend_op_q   <= '0;
      rows_q      <= lgs_pkg::CFG_W'(lgs_pkg::CFG_RESET);
      cols_q      <= lgs_pkg::CFG_W'(lgs_pkg::CFG_RESET);
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      s_q         <= s_d;
      out_valid_q <= out_valid_d;
      pend_op_q   <= pend_op_d;
      if (cfg_we_i) begin
        unique case (lgs_pkg::cfg_idx_e'(cfg_idx_i))
          lgs_pkg::CFG_ROWS: rows_q <= cfg_wdata_i;
          lgs_pkg::CFG_COLS: cols_q <= cfg_wdata_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    up_q         <= up_d;
    mid_q        <= mid_d;
    pend_row_q   <= pend_row_d;
    pend_ok_q    <= pend_ok_d;
    pend_cells_q <= pend_cells_d;
    out_q        <= out_d;
  end

  always_comb begin
    state_d      = state_q;
    clr_d        = clr_q;
    s_d          = s_q;
    up_d         = up_q;
    mid_d        = mid_q;
    pend_op_d    = pend_op_q;
    pend_row_d   = pend_row_q;
    pend_ok_d    = pend_ok_q;
    pend_cells_d = pend_cells_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    out_d        = out_q;
    in_ready_o   = 1'b0;
    wr_en        = 1'b0;
    wr_addr      = '0;
    wr_data      = '0;
    rd_en        = 1'b0;
    rd_addr      = '0;

    unique case (state_q)
      lgs_pkg::ST_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_q;
        if (clr_q == AW'(MAX_ROWS - 1)) begin
          state_d = lgs_pkg::ST_IDLE;
        end else begin
          clr_d = clr_q + AW'(1);
        end
      end

      lgs_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          pend_op_d    = in_data_i.op;
          pend_row_d   = in_data_i.row_index;
          pend_ok_d    = in_row_ok;
          pend_cells_d = in_data_i.row_cells & col_mask;
          state_d      = lgs_pkg::ST_FIN;
          unique case (lgs_pkg::op_e'(in_data_i.op))
            lgs_pkg::OP_WRITE: begin
              wr_en   = in_row_ok;
              wr_addr = AW'(in_data_i.row_index);
              wr_data = in_data_i.row_cells & col_mask;
            end
            lgs_pkg::OP_READ: begin
              rd_en   = in_row_ok;
              rd_addr = AW'(in_data_i.row_index);
            end
            lgs_pkg::OP_STEP: begin
              up_d  = '0;
              mid_d = '0;
              s_d   = '0;
              if (r_eff != '0) begin
                rd_en   = 1'b1;
                state_d = lgs_pkg::ST_STEP;
              end
            end
            default: ;
          endcase
        end
      end

      lgs_pkg::ST_STEP: begin
        // prefetch the row below the next one
        if (s_nxt < {1'b0, r_eff}) begin
          rd_en   = 1'b1;
          rd_addr = AW'(s_nxt);
        end
        if (s_q != '0) begin
          wr_en   = 1'b1;
          wr_addr = AW'(s_q - RW'(1));
          wr_data = next_row;
        end
        up_d  = mid_q;
        mid_d = incoming;
        if (s_q == r_eff) begin
          state_d = lgs_pkg::ST_FIN;
        end else begin
          s_d = s_nxt[RW-1:0];
        end
      end

      lgs_pkg::ST_FIN: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_d       = '0;
          unique case (lgs_pkg::op_e'(pend_op_q))
            lgs_pkg::OP_WRITE: begin
              out_d.row_index_out = pend_row_q;
              out_d.row_cells_out = pend_ok_q ? pend_cells_q : '0;
            end
            lgs_pkg::OP_READ: begin
              out_d.row_index_out = pend_row_q;
              out_d.row_cells_out = pend_ok_q ? (rd_data & col_mask) : '0;
            end
            lgs_pkg::OP_STEP: begin
              out_d.step_done = 1'b1;
            end
            default: ;
          endcase
          state_d = lgs_pkg::ST_IDLE;
        end
      end

      default: state_d = lgs_pkg::ST_IDLE;
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

/* sim/life_generation_step_tb.sv */
`timescale 1ns / 1ps

module life_generation_step_tb;

  localparam int unsigned CLK_PERIOD   = 8;
  localparam int unsigned CYCLE_LIMIT  = 1_000_000;
  localparam int unsigned PHASES       = 11;
  localparam int unsigned PHASE_ITEMS  = 103;
  localparam int unsigned DIRECTED_N   = 25;
  localparam int unsigned DRAIN_CYCLES = lgs_pkg::DEF_MAX_ROWS + 16;
  localparam logic [1:0]  OP_UNUSED    = 2'd3;

  localparam logic [lgs_pkg::ROW_W-1:0] ALL_LIVE  = '1;
  localparam logic [lgs_pkg::ROW_W-1:0] NO_LIVE   = '0;
  localparam logic [lgs_pkg::ROW_W-1:0] BLINKER   = 64'h0000_0000_0000_00E0;
  localparam logic [lgs_pkg::ROW_W-1:0] EDGE_PAIR = 64'h8000_0000_0000_0001;
  localparam logic [lgs_pkg::ROW_W-1:0] EDGE_QUAD = 64'hC000_0000_0000_0003;
  localparam logic [lgs_pkg::ROW_W-1:0] CHECKER   = 64'hA5A5_A5A5_A5A5_A5A5;

  typedef struct packed {
    lgs_pkg::in_t  item;
    logic          fixed;
    lgs_pkg::out_t want;
  } directed_vec_t;

  logic                          clk       = 1'b0;
  logic                          rst_n     = 1'b0;
  logic                          in_valid  = 1'b0;
  lgs_pkg::in_t                  in_data   = '0;
  logic                          in_ready;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  lgs_pkg::out_t                 out_data;
  logic                          cfg_we    = 1'b0;
  logic [lgs_pkg::CFG_IDX_W-1:0] cfg_idx   = '0;
  logic [lgs_pkg::CFG_W-1:0]     cfg_wdata = '0;

  int unsigned sender_idle_pct = 0;
  int unsigned stall_pct       = 0;
  int unsigned mismatches      = 0;
  int unsigned cycle_count     = 0;

  // grid as the block should hold it, plus its size registers
  logic [lgs_pkg::ROW_W-1:0] grid_model [lgs_pkg::DEF_MAX_ROWS];
  logic [lgs_pkg::CFG_W-1:0] rows_cfg = lgs_pkg::CFG_W'(lgs_pkg::CFG_RESET);
  logic [lgs_pkg::CFG_W-1:0] cols_cfg = lgs_pkg::CFG_W'(lgs_pkg::CFG_RESET);
  lgs_pkg::out_t             pending_results [$];

  life_generation_step dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  function automatic int rows_active();
    int n;
    n = int'(rows_cfg);
    if (n > lgs_pkg::DEF_MAX_ROWS) n = lgs_pkg::DEF_MAX_ROWS;
    return n;
  endfunction

  function automatic logic [lgs_pkg::ROW_W-1:0] cols_mask();
    int c;
    c = int'(cols_cfg);
    if (c > lgs_pkg::DEF_MAX_COLS) c = lgs_pkg::DEF_MAX_COLS;
    if (c >= lgs_pkg::ROW_W) return ALL_LIVE;
    return (64'd1 << c) - 64'd1;
  endfunction

  // one B3/S23 generation over the active window, dead outside it
  function automatic void evolve_grid();
    logic [lgs_pkg::ROW_W-1:0] old_gen [lgs_pkg::DEF_MAX_ROWS];
    logic [lgs_pkg::ROW_W-1:0] up, mid, dn, nxt, cm;
    logic [7:0]                nb;
    int                        nrows, cnt;
    nrows = rows_active();
    cm    = cols_mask();
    for (int i = 0; i < nrows; i++) old_gen[i] = grid_model[i] & cm;
    for (int i = 0; i < nrows; i++) begin
      up  = (i > 0) ? old_gen[i-1] : NO_LIVE;
      mid = old_gen[i];
      dn  = (i + 1 < nrows) ? old_gen[i+1] : NO_LIVE;
      nxt = NO_LIVE;
      for (int j = 0; j < lgs_pkg::ROW_W; j++) begin
        if (cm[j]) begin
          nb    = '0;
          nb[0] = up[j];
          nb[1] = dn[j];
          if (j > 0) begin
            nb[2] = up[j-1];
            nb[3] = mid[j-1];
            nb[4] = dn[j-1];
          end
          if (j < lgs_pkg::ROW_W - 1) begin
            nb[5] = up[j+1];
            nb[6] = mid[j+1];
            nb[7] = dn[j+1];
          end
          cnt = $countones(nb);
          if ((mid[j] && (cnt == 2 || cnt == 3)) || (!mid[j] && cnt == 3)) nxt[j] = 1'b1;
        end
      end
      grid_model[i] = nxt;
    end
  endfunction

  function automatic lgs_pkg::out_t predict_result(lgs_pkg::in_t it);
    lgs_pkg::out_t             r;
    logic [lgs_pkg::ROW_W-1:0] cm;
    int                        row;
    r   = '0;
    cm  = cols_mask();
    row = int'(it.row_index);
    case (it.op)
      lgs_pkg::OP_WRITE: begin
        r.row_index_out = it.row_index;
        if (row < lgs_pkg::DEF_MAX_ROWS) begin
          grid_model[row] = it.row_cells & cm;
          r.row_cells_out = grid_model[row];
        end
      end
      lgs_pkg::OP_READ: begin
        r.row_index_out = it.row_index;
        if (row < lgs_pkg::DEF_MAX_ROWS) r.row_cells_out = grid_model[row] & cm;
      end
      lgs_pkg::OP_STEP: begin
        evolve_grid();
        r.step_done = 1'b1;
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic logic [lgs_pkg::ROW_W-1:0] random_cells();
    logic [lgs_pkg::ROW_W-1:0] a, b;
    a = {$urandom, $urandom};
    b = {$urandom, $urandom};
    case ($urandom_range(0, 7))
      0:       return ALL_LIVE;
      1:       return NO_LIVE;
      2, 3, 4: return a & b;
      5:       return a & b & {$urandom, $urandom};
      default: return a;
    endcase
  endfunction

  function automatic lgs_pkg::in_t random_item();
    lgs_pkg::in_t it;
    int unsigned  pick;
    int           nrows;
    pick  = $urandom_range(0, 99);
    nrows = rows_active();
    if (pick < 36) it.op = lgs_pkg::OP_WRITE;
    else if (pick < 70) it.op = lgs_pkg::OP_READ;
    else if (pick < 92) it.op = lgs_pkg::OP_STEP;
    else it.op = OP_UNUSED;
    // mostly rows inside the active window, some anywhere
    if (nrows > 0 && $urandom_range(0, 4) != 0) begin
      it.row_index = lgs_pkg::ROW_IDX_W'($urandom_range(0, nrows - 1));
    end else begin
      it.row_index = lgs_pkg::ROW_IDX_W'($urandom_range(0, (1 << lgs_pkg::ROW_IDX_W) - 1));
    end
    it.row_cells = random_cells();
    return it;
  endfunction

  function automatic void note_mismatch(string field, logic [lgs_pkg::ROW_W-1:0] want,
                                        logic [lgs_pkg::ROW_W-1:0] got);
    if (mismatches < 10) begin
      $display("mismatch on %s: expected %h, got %h", field, want, got);
    end
    mismatches++;
  endfunction

  // hold valid across back-to-back transactions, drop it only for an idle gap
  task automatic send_item(lgs_pkg::in_t it, logic fixed, lgs_pkg::out_t want);
    lgs_pkg::out_t predicted;
    @(negedge clk);
    while (sender_idle_pct != 0 && $urandom_range(0, 99) < sender_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_data  = it;
    do @(posedge clk); while (in_ready !== 1'b1);
    predicted = predict_result(it);
    pending_results.push_back(fixed ? want : predicted);
  endtask

  task automatic drain_block();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_grid_size(logic [lgs_pkg::CFG_W-1:0] rows,
                               logic [lgs_pkg::CFG_W-1:0] cols);
    drain_block();
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_idx   = lgs_pkg::CFG_ROWS;
    cfg_wdata = rows;
    @(negedge clk);
    cfg_idx   = lgs_pkg::CFG_COLS;
    cfg_wdata = cols;
    @(negedge clk);
    cfg_we    = 1'b0;
    rows_cfg  = rows;
    cols_cfg  = cols;
  endtask

  always @(negedge clk) out_ready <= ($urandom_range(0, 99) >= stall_pct);

  always @(posedge clk) begin
    lgs_pkg::out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        note_mismatch("unexpected transaction, cells", NO_LIVE, out_data.row_cells_out);
      end else begin
        want = pending_results.pop_front();
        if (out_data.row_index_out !== want.row_index_out) begin
          note_mismatch("row index", lgs_pkg::ROW_W'(want.row_index_out),
                        lgs_pkg::ROW_W'(out_data.row_index_out));
        end
        if (out_data.row_cells_out !== want.row_cells_out) begin
          note_mismatch("row cells", want.row_cells_out, out_data.row_cells_out);
        end
        if (out_data.step_done !== want.step_done) begin
          note_mismatch("step done", lgs_pkg::ROW_W'(want.step_done),
                        lgs_pkg::ROW_W'(out_data.step_done));
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("life_generation_step_tb: done, errors");
      $finish;
    end
  end

  initial begin
    directed_vec_t             plan [DIRECTED_N];
    logic [lgs_pkg::CFG_W-1:0] rows_plan [PHASES];
    logic [lgs_pkg::CFG_W-1:0] cols_plan [PHASES];
    lgs_pkg::in_t              seed;
    int                        seeds;

    for (int r = 0; r < lgs_pkg::DEF_MAX_ROWS; r++) grid_model[r] = NO_LIVE;

    // fixed expectations where the answer is plain, predictor elsewhere
    plan = '{
      '{'{lgs_pkg::OP_READ,  6'd0,  NO_LIVE},   1'b1, '{6'd0,  NO_LIVE,   1'b0}},
      '{'{lgs_pkg::OP_READ,  6'd63, NO_LIVE},   1'b1, '{6'd63, NO_LIVE,   1'b0}},
      '{'{lgs_pkg::OP_WRITE, 6'd0,  ALL_LIVE},  1'b1, '{6'd0,  ALL_LIVE,  1'b0}},
      '{'{lgs_pkg::OP_WRITE, 6'd63, ALL_LIVE},  1'b1, '{6'd63, ALL_LIVE,  1'b0}},
      '{'{lgs_pkg::OP_READ,  6'd0,  NO_LIVE},   1'b1, '{6'd0,  ALL_LIVE,  1'b0}},
      '{'{lgs_pkg::OP_STEP,  6'd17, ALL_LIVE},  1'b1, '{6'd0,  NO_LIVE,   1'b1}},
      '{'{lgs_pkg::OP_READ,  6'd0,  NO_LIVE},   1'b0, '0},
      '{'{lgs_pkg::OP_READ,  6'd1,  NO_LIVE},   1'b0, '0},
      '{'{lgs_pkg::OP_READ,  6'd62, NO_LIVE},   1'b0, '0},
      '{'{lgs_pkg::OP_READ,  6'd63, NO_LIVE},   1'b0, '0},
      '{'{lgs_pkg::OP_WRITE, 6'd0,  NO_LIVE},   1'b1, '{6'd0,  NO_LIVE,   1'b0}},
      '{'{lgs_pkg::OP_WRITE, 6'd63, NO_LIVE},   1'b1, '{6'd63, NO_LIVE,   1'b0}},
      '{'{lgs_pkg::OP_WRITE, 6'd1,  NO_LIVE},   1'b1, '{6'd1,  NO_LIVE,   1'b0}},
      '{'{lgs_pkg::OP_WRITE, 6'd62, NO_LIVE},   1'b1, '{6'd62, NO_LIVE,   1'b0}},
      '{'{lgs_pkg::OP_WRITE, 6'd10, BLINKER},   1'b1, '{6'd10, BLINKER,   1'b0}},
      '{'{lgs_pkg::OP_STEP,  6'd0,  NO_LIVE},   1'b1, '{6'd0,  NO_LIVE,   1'b1}},
      '{'{lgs_pkg::OP_READ,  6'd9,  NO_LIVE},   1'b0, '0},
      '{'{lgs_pkg::OP_READ,  6'd10, NO_LIVE},   1'b0, '0},
      '{'{lgs_pkg::OP_READ,  6'd11, NO_LIVE},   1'b0, '0},
      '{'{lgs_pkg::OP_WRITE, 6'd30, EDGE_PAIR}, 1'b1, '{6'd30, EDGE_PAIR, 1'b0}},
      '{'{lgs_pkg::OP_WRITE, 6'd31, EDGE_QUAD}, 1'b1, '{6'd31, EDGE_QUAD, 1'b0}},
      '{'{lgs_pkg::OP_STEP,  6'd63, CHECKER},   1'b1, '{6'd0,  NO_LIVE,   1'b1}},
      '{'{lgs_pkg::OP_READ,  6'd30, NO_LIVE},   1'b0, '0},
      '{'{OP_UNUSED,         6'd5,  CHECKER},   1'b1, '{6'd0,  NO_LIVE,   1'b0}},
      '{'{lgs_pkg::OP_READ,  6'd31, ALL_LIVE},  1'b0, '0}
    };

    // entry zero keeps the reset sizes
    rows_plan = '{7'd64, 7'd3,  7'd64, 7'd0,  7'd64, 7'd127, 7'd1, 7'd16, 7'd2,  7'd0, 7'd0};
    cols_plan = '{7'd64, 7'd64, 7'd1,  7'd64, 7'd0,  7'd127, 7'd3, 7'd33, 7'd64, 7'd0, 7'd0};
    for (int p = PHASES - 2; p < PHASES; p++) begin
      rows_plan[p] = lgs_pkg::CFG_W'($urandom_range(1, (1 << lgs_pkg::CFG_W) - 1));
      cols_plan[p] = lgs_pkg::CFG_W'($urandom_range(1, (1 << lgs_pkg::CFG_W) - 1));
    end

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (plan[k]) send_item(plan[k].item, plan[k].fixed, plan[k].want);

    for (int p = 0; p < PHASES; p++) begin
      if (p != 0) set_grid_size(rows_plan[p], cols_plan[p]);
      case (p % 4)
        0: begin sender_idle_pct = 0;  stall_pct = 0;  end
        1: begin sender_idle_pct = 62; stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  stall_pct = 62; end
        default: begin sender_idle_pct = 18; stall_pct = 18; end
      endcase
      // fill the active window before mixing in steps
      seeds = rows_active();
      for (int r = 0; r < seeds; r++) begin
        seed.op        = lgs_pkg::OP_WRITE;
        seed.row_index = lgs_pkg::ROW_IDX_W'(r);
        seed.row_cells = random_cells();
        send_item(seed, 1'b0, '0);
      end
      for (int n = seeds; n < PHASE_ITEMS; n++) send_item(random_item(), 1'b0, '0);
    end

    drain_block();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("life_generation_step_tb: done, clean");
    end else begin
      $display("life_generation_step_tb: done, errors");
    end
    $finish;
  end

endmodule

/* life_generation_step.f */
rtl/core/lgs_pkg.sv
rtl/core/lgs_lane.sv
rtl/core/lgs_row_eval.sv
rtl/core/lgs_grid_mem.sv
rtl/core/life_generation_step.sv
sim/life_generation_step_tb.sv
